### design/mbwt_pkg.sv
package mbwt_pkg;

  localparam int unsigned UAddrBits = 5;

  localparam logic [31:0] PatA = 32'hAAAA_AAAA;
  localparam logic [31:0] PatB = 32'h5555_5555;
  localparam logic [31:0] SizeMaskRst = 32'h3FFF_FFFF;

  typedef logic [UAddrBits-1:0] uaddr_t;

  typedef struct packed {
    logic        action;
    logic [31:0] read_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] byte_offset;
    logic [31:0] write_data;
    logic [1:0]  fail_kind;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FK_PASS = 2'd0,
    FK_DATA = 2'd1,
    FK_ADDR = 2'd2
  } fail_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DATA = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW0 = 3'd3,
    PH_LOW  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    OFF_ZERO   = 2'd0,
    OFF_PROBE  = 2'd1,
    OFF_TARGET = 2'd2
  } off_sel_e;

  typedef enum logic [1:0] {
    DAT_ZERO = 2'd0,
    DAT_WALK = 2'd1,
    DAT_A    = 2'd2,
    DAT_B    = 2'd3
  } dat_sel_e;

  typedef enum logic [1:0] {
    WK_HOLD  = 2'd0,
    WK_ONE   = 2'd1,
    WK_SHIFT = 2'd2
  } walk_op_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_ZERO  = 2'd1,
    OP_FOUR  = 2'd2,
    OP_SHIFT = 2'd3
  } off_op_e;

  typedef enum logic [3:0] {
    CN_NEVER      = 4'd0,
    CN_ALWAYS     = 4'd1,
    CN_RD_NE_WALK = 4'd2,
    CN_WALK_NZ    = 4'd3,
    CN_PROBE_IN   = 4'd4,
    CN_PROBE_OUT  = 4'd5,
    CN_TARGET_OUT = 4'd6,
    CN_RD_NE_A    = 4'd7,
    CN_LOW_FAIL   = 4'd8
  } cond_e;

  // one microcode word
  typedef struct packed {
    logic     emit;
    cmd_e     cmd;
    off_sel_e off_sel;
    dat_sel_e dat_sel;
    fail_e    kind;
    walk_op_e walk_op;
    off_op_e  probe_op;
    off_op_e  target_op;
    logic     phase_wr;
    phase_e   phase;
    cond_e    cond;
    uaddr_t   jump;
    logic     done;
  } uword_t;

  // datapath status seen by the jump logic
  typedef struct packed {
    logic rd_ne_walk;
    logic walk_nz;
    logic probe_in;
    logic target_in;
    logic rd_ne_a;
    logic low_fail;
  } status_t;

  // microprogram entry points and jump targets
  localparam uaddr_t US_START     = 5'd0;
  localparam uaddr_t US_DATA_WR   = 5'd1;
  localparam uaddr_t US_DATA_RD   = 5'd2;
  localparam uaddr_t US_DATA_CHK  = 5'd3;
  localparam uaddr_t US_DATA_SHL  = 5'd4;
  localparam uaddr_t US_DATA_NXT  = 5'd5;
  localparam uaddr_t US_FILL_INIT = 5'd6;
  localparam uaddr_t US_FILL_TST  = 5'd7;
  localparam uaddr_t US_FILL_WR   = 5'd8;
  localparam uaddr_t US_HIGH_INIT = 5'd9;
  localparam uaddr_t US_HIGH_TST  = 5'd10;
  localparam uaddr_t US_HIGH_RD   = 5'd11;
  localparam uaddr_t US_HIGH_CHK  = 5'd12;
  localparam uaddr_t US_HIGH_SHL  = 5'd13;
  localparam uaddr_t US_HIGH_NXT  = 5'd14;
  localparam uaddr_t US_HIGH_END  = 5'd15;
  localparam uaddr_t US_LOW_START = 5'd16;
  localparam uaddr_t US_LOW_WR    = 5'd17;
  localparam uaddr_t US_LOW_RD0   = 5'd18;
  localparam uaddr_t US_LOW0_CHK  = 5'd19;
  localparam uaddr_t US_LOW0_INIT = 5'd20;
  localparam uaddr_t US_LOW_TST   = 5'd21;
  localparam uaddr_t US_LOW_RD    = 5'd22;
  localparam uaddr_t US_LOW_CHK   = 5'd23;
  localparam uaddr_t US_LOW_SHL   = 5'd24;
  localparam uaddr_t US_FINISH    = 5'd25;
  localparam uaddr_t US_REP_DATA  = 5'd26;
  localparam uaddr_t US_REP_PROBE = 5'd27;
  localparam uaddr_t US_REP_ADDR0 = 5'd28;
  localparam uaddr_t US_REP_PASS  = 5'd29;

endpackage

### design/mbwt_useq.sv
module mbwt_useq
  import mbwt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    go_i,
  input  uaddr_t  entry_i,
  input  status_t status_i,
  input  logic    out_free_i,
  output uword_t  uw_o,
  output logic    fire_o,
  output logic    busy_o
);

  uaddr_t upc_q, upc_d;
  logic   busy_q, busy_d;
  uword_t uw;
  logic   taken;

  // control store
  always_comb begin
    uw = '{emit: 1'b0, cmd: CMD_WRITE, off_sel: OFF_ZERO, dat_sel: DAT_ZERO,
           kind: FK_PASS, walk_op: WK_HOLD, probe_op: OP_HOLD, target_op: OP_HOLD,
           phase_wr: 1'b0, phase: PH_IDLE, cond: CN_NEVER, jump: US_START,
           done: 1'b0};
    case (upc_q)
      US_START: begin
        uw.walk_op = WK_ONE;
        uw.probe_op = OP_FOUR;
        uw.target_op = OP_ZERO;
      end
      US_DATA_WR: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_WRITE;
        uw.dat_sel = DAT_WALK;
      end
      US_DATA_RD: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_READ;
        uw.phase_wr = 1'b1;
        uw.phase = PH_DATA;
        uw.done = 1'b1;
      end
      US_DATA_CHK: begin
        uw.cond = CN_RD_NE_WALK;
        uw.jump = US_REP_DATA;
      end
      US_DATA_SHL: begin
        uw.walk_op = WK_SHIFT;
      end
      US_DATA_NXT: begin
        uw.cond = CN_WALK_NZ;
        uw.jump = US_DATA_WR;
      end
      US_FILL_INIT: begin
        uw.probe_op = OP_FOUR;
      end
      US_FILL_TST: begin
        uw.cond = CN_PROBE_OUT;
        uw.jump = US_HIGH_INIT;
      end
      US_FILL_WR: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_WRITE;
        uw.off_sel = OFF_PROBE;
        uw.dat_sel = DAT_A;
        uw.probe_op = OP_SHIFT;
        uw.cond = CN_ALWAYS;
        uw.jump = US_FILL_TST;
      end
      US_HIGH_INIT: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_WRITE;
        uw.dat_sel = DAT_B;
        uw.probe_op = OP_FOUR;
      end
      US_HIGH_TST: begin
        uw.cond = CN_PROBE_OUT;
        uw.jump = US_HIGH_END;
      end
      US_HIGH_RD: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_READ;
        uw.off_sel = OFF_PROBE;
        uw.phase_wr = 1'b1;
        uw.phase = PH_HIGH;
        uw.done = 1'b1;
      end
      US_HIGH_CHK: begin
        uw.cond = CN_RD_NE_A;
        uw.jump = US_REP_PROBE;
      end
      US_HIGH_SHL: begin
        uw.probe_op = OP_SHIFT;
      end
      US_HIGH_NXT: begin
        uw.cond = CN_PROBE_IN;
        uw.jump = US_HIGH_RD;
      end
      US_HIGH_END: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_WRITE;
        uw.dat_sel = DAT_A;
        uw.target_op = OP_FOUR;
      end
      US_LOW_START: begin
        uw.cond = CN_TARGET_OUT;
        uw.jump = US_REP_PASS;
      end
      US_LOW_WR: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_WRITE;
        uw.off_sel = OFF_TARGET;
        uw.dat_sel = DAT_B;
      end
      US_LOW_RD0: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_READ;
        uw.phase_wr = 1'b1;
        uw.phase = PH_LOW0;
        uw.done = 1'b1;
      end
      US_LOW0_CHK: begin
        uw.cond = CN_RD_NE_A;
        uw.jump = US_REP_ADDR0;
      end
      US_LOW0_INIT: begin
        uw.probe_op = OP_FOUR;
      end
      US_LOW_TST: begin
        uw.cond = CN_PROBE_OUT;
        uw.jump = US_FINISH;
      end
      US_LOW_RD: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_READ;
        uw.off_sel = OFF_PROBE;
        uw.phase_wr = 1'b1;
        uw.phase = PH_LOW;
        uw.done = 1'b1;
      end
      US_LOW_CHK: begin
        uw.cond = CN_LOW_FAIL;
        uw.jump = US_REP_PROBE;
      end
      US_LOW_SHL: begin
        uw.probe_op = OP_SHIFT;
        uw.cond = CN_ALWAYS;
        uw.jump = US_LOW_TST;
      end
      US_FINISH: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_WRITE;
        uw.off_sel = OFF_TARGET;
        uw.dat_sel = DAT_A;
        uw.target_op = OP_SHIFT;
        uw.cond = CN_ALWAYS;
        uw.jump = US_LOW_START;
      end
      US_REP_DATA: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_REPORT;
        uw.kind = FK_DATA;
        uw.phase_wr = 1'b1;
        uw.done = 1'b1;
      end
      US_REP_PROBE: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_REPORT;
        uw.off_sel = OFF_PROBE;
        uw.kind = FK_ADDR;
        uw.phase_wr = 1'b1;
        uw.done = 1'b1;
      end
      US_REP_ADDR0: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_REPORT;
        uw.kind = FK_ADDR;
        uw.phase_wr = 1'b1;
        uw.done = 1'b1;
      end
      US_REP_PASS: begin
        uw.emit = 1'b1;
        uw.cmd = CMD_REPORT;
        uw.phase_wr = 1'b1;
        uw.done = 1'b1;
      end
      default: begin
        // unused address: park
        uw.done = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (uw.cond)
      CN_NEVER:      taken = 1'b0;
      CN_ALWAYS:     taken = 1'b1;
      CN_RD_NE_WALK: taken = status_i.rd_ne_walk;
      CN_WALK_NZ:    taken = status_i.walk_nz;
      CN_PROBE_IN:   taken = status_i.probe_in;
      CN_PROBE_OUT:  taken = !status_i.probe_in;
      CN_TARGET_OUT: taken = !status_i.target_in;
      CN_RD_NE_A:    taken = status_i.rd_ne_a;
      CN_LOW_FAIL:   taken = status_i.low_fail;
      default:       taken = 1'b0;
    endcase
  end

  // a step that emits waits for room in the output register
  assign fire_o = busy_q && (!uw.emit || out_free_i);

  always_comb begin
    upc_d = upc_q;
    busy_d = busy_q;
    if (go_i) begin
      upc_d = entry_i;
      busy_d = 1'b1;
    end else if (fire_o) begin
      upc_d = taken ? uw.jump : upc_q + uaddr_t'(1);
      if (uw.done) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= US_START;
      busy_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      busy_q <= busy_d;
    end
  end

  assign uw_o = uw;
  assign busy_o = busy_q;

endmodule

### design/memory_bus_wiring_test_top.sv
// Throughput: one microcode step per cycle, but a step that emits a word waits for room
// in the output register; an item keeps the sequencer busy until a step marked done, and
// the address fill pass writes one word per probed offset; any output stall adds to this.
// The step rate of the control store and the single output register set the throughput.
// Reset: idle, no read pending, size_mask 0x3FFFFFFF; a start word restarts a run once the sequencer is idle.
module memory_bus_wiring_test_top
  import mbwt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] size_mask_q;
  logic [31:0] walk_q, walk_d;
  logic [32:0] probe_q, probe_d;
  logic [32:0] target_q, target_d;
  logic [31:0] rd_q;
  phase_e      phase_q, phase_d;
  logic        pending_q, pending_d;
  out_word_t   out_q;
  logic        out_valid_q;

  uword_t  uw;
  status_t status;
  logic    fire, busy, go, in_acc, out_free, load_out;
  uaddr_t  entry;
  logic [31:0] off_val, dat_val;

  mbwt_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .entry_i    (entry),
    .status_i   (status),
    .out_free_i (out_free),
    .uw_o       (uw),
    .fire_o     (fire),
    .busy_o     (busy)
  );

  assign in_stall_o = busy;
  assign in_acc = in_valid_i && !busy;
  assign cfg_ready_o = !busy;

  // dispatch of an accepted word
  always_comb begin
    go = 1'b0;
    entry = US_START;
    if (in_acc) begin
      if (!in_data_i.action) begin
        go = 1'b1;
      end else if (pending_q) begin
        case (phase_q)
          PH_DATA: begin go = 1'b1; entry = US_DATA_CHK; end
          PH_HIGH: begin go = 1'b1; entry = US_HIGH_CHK; end
          PH_LOW0: begin go = 1'b1; entry = US_LOW0_CHK; end
          PH_LOW:  begin go = 1'b1; entry = US_LOW_CHK; end
          default: go = 1'b0;
        endcase
      end
    end
  end

  assign status.rd_ne_walk = rd_q != walk_q;
  assign status.walk_nz    = walk_q != '0;
  assign status.probe_in   = (probe_q[31:0] & size_mask_q) != '0;
  assign status.target_in  = (target_q[31:0] & size_mask_q) != '0;
  assign status.rd_ne_a    = rd_q != PatA;
  assign status.low_fail   = (rd_q != PatA) && (probe_q != target_q);

  always_comb begin
    case (uw.off_sel)
      OFF_PROBE:  off_val = probe_q[31:0];
      OFF_TARGET: off_val = target_q[31:0];
      default:    off_val = '0;
    endcase
    case (uw.dat_sel)
      DAT_WALK: dat_val = walk_q;
      DAT_A:    dat_val = PatA;
      DAT_B:    dat_val = PatB;
      default:  dat_val = '0;
    endcase
  end

  always_comb begin
    walk_d = walk_q;
    probe_d = probe_q;
    target_d = target_q;
    phase_d = phase_q;
    pending_d = pending_q;
    if (in_acc && in_data_i.action) begin
      pending_d = 1'b0;
      if (pending_q && !go) begin
        phase_d = PH_IDLE;
      end
    end
    if (fire) begin
      case (uw.walk_op)
        WK_ONE:   walk_d = 32'd1;
        WK_SHIFT: walk_d = {walk_q[30:0], 1'b0};
        default:  walk_d = walk_q;
      endcase
      case (uw.probe_op)
        OP_ZERO:  probe_d = '0;
        OP_FOUR:  probe_d = 33'd4;
        OP_SHIFT: probe_d = {probe_q[31:0], 1'b0};
        default:  probe_d = probe_q;
      endcase
      case (uw.target_op)
        OP_ZERO:  target_d = '0;
        OP_FOUR:  target_d = 33'd4;
        OP_SHIFT: target_d = {target_q[31:0], 1'b0};
        default:  target_d = target_q;
      endcase
      if (uw.phase_wr) begin
        phase_d = uw.phase;
        pending_d = uw.phase != PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_mask_q <= SizeMaskRst;
      walk_q <= 32'd1;
      probe_q <= 33'd4;
      target_q <= '0;
      phase_q <= PH_IDLE;
      pending_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        size_mask_q <= cfg_data_i;
      end
      walk_q <= walk_d;
      probe_q <= probe_d;
      target_q <= target_d;
      phase_q <= phase_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= in_data_i.read_data;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = fire && uw.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.command <= uw.cmd;
      out_q.byte_offset <= off_val;
      out_q.write_data <= dat_val;
      out_q.fail_kind <= uw.kind;
      // reads and reports always close the words of an item
      out_q.last <= uw.cmd != CMD_WRITE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTH
  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && uw.done |=> !busy)
    else $error("sequencer still busy after final step");

  a_last_matches_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.command != CMD_WRITE)))
    else $error("last flag does not match command");

  a_report_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.command != CMD_WRITE) |-> out_q.write_data == '0)
    else $error("read or report carries write data");

  a_pending_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && pending_q |-> phase_q != PH_IDLE)
    else $error("read pending with idle phase");

  a_no_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> !busy)
    else $error("dispatch while sequencer busy");
`endif

endmodule
